>>> rtl/core/drr_pkg.sv
package drr_pkg;

	localparam int MAX_ITEMS     = 64;
	localparam int VALUE_BITS    = 32;
	localparam int IN_DATA_BITS  = 32;
	localparam int CODE_BITS     = 6;
	localparam int OUT_DATA_BITS = 8;
	localparam int IDX_BITS      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_BITS      = $clog2(MAX_ITEMS + 1);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [CODE_BITS-1:0]  code_t;

	// Request from the load side to the rank engine.
	typedef struct packed {
		logic start;
		cnt_t count;
	} rank_req_t;

	// Read port of the code store, used while the codes go out.
	typedef struct packed {
		logic en;
		idx_t addr;
	} code_rd_t;

endpackage

>>> rtl/core/dense_rank_recoder_top.sv
// Dense rank recoder. Values stream in on the slave side at one transfer per
// cycle while the block is loading and are written to a 64-entry value memory;
// values beyond the capacity are dropped and flag overflow on every code of that
// set. After the transfer that carries tlast the block stops accepting input and
// ranks the set: it sweeps the value memory once per distinct value plus once
// more, reading one entry per cycle through its single read port. The codes then
// leave in load order from a code memory; the next code read is not started
// before the previous code has reached the output register.
// Input is taken again as soon as the final code sits in the output register.
module dense_rank_recoder_top import drr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // value
	input  logic                     s_tlast,   // last
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,   // code, then zero fill
	output logic                     m_tlast,   // last_res
	output logic                     m_tuser    // overflow
);

	typedef enum logic [2:0] {
		PH_LOAD = 3'b001,
		PH_RANK = 3'b010,
		PH_EMIT = 3'b100
	} phase_t;

	phase_t    phase_q;
	cnt_t      count_q;
	logic      ovf_q;
	logic      start_q;
	cnt_t      emit_idx_q;
	logic      pend_s1;
	logic      pend_last_s1;
	logic      m_valid_q;
	code_t     m_code_q;
	logic      m_last_q;
	logic      m_ovf_q;

	logic      acc;
	logic      room;
	logic      rk_done;
	logic      vrd_en;
	idx_t      vrd_addr;
	value_t    vrd_data;
	code_t     crd_data;
	rank_req_t req;
	code_rd_t  crd;

	assign s_tready = (phase_q == PH_LOAD);
	assign acc      = s_tvalid && s_tready;
	assign room     = (count_q < cnt_t'(MAX_ITEMS));

	assign req.start = start_q;
	assign req.count = count_q;

	// A code read is started only when the output register is free by the
	// time the data comes back.
	assign crd.en   = (phase_q == PH_EMIT) && (emit_idx_q < count_q) && !pend_s1
		&& (!m_valid_q || m_tready);
	assign crd.addr = emit_idx_q[IDX_BITS-1:0];

	drr_value_mem u_value_mem (
		.clk   (clk),
		.we    (acc && room),
		.waddr (count_q[IDX_BITS-1:0]),
		.wdata (value_t'(s_tdata)),
		.re    (vrd_en),
		.raddr (vrd_addr),
		.rdata (vrd_data)
	);

	drr_ranker u_ranker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.done     (rk_done),
		.vrd_en   (vrd_en),
		.vrd_addr (vrd_addr),
		.vrd_data (vrd_data),
		.crd      (crd),
		.crd_data (crd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			start_q    <= 1'b0;
			emit_idx_q <= '0;
			pend_s1    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (pend_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (phase_q)
				PH_LOAD: begin
					if (acc) begin
						if (room) begin
							count_q <= count_q + cnt_t'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							phase_q <= PH_RANK;
							start_q <= 1'b1;
						end
					end
				end
				PH_RANK: begin
					if (rk_done) begin
						phase_q    <= PH_EMIT;
						emit_idx_q <= '0;
					end
				end
				PH_EMIT: begin
					if (crd.en) begin
						emit_idx_q <= emit_idx_q + cnt_t'(1);
						pend_s1    <= 1'b1;
					end
					if (pend_s1) begin
						pend_s1 <= 1'b0;
						if (pend_last_s1) begin
							phase_q <= PH_LOAD;
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				default: begin
					phase_q <= PH_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (crd.en) begin
			pend_last_s1 <= ((emit_idx_q + cnt_t'(1)) == count_q);
		end
		if (pend_s1) begin
			m_code_q <= crd_data;
			m_last_q <= pend_last_s1;
			m_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - CODE_BITS){1'b0}}, m_code_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ovf_q;

endmodule

>>> rtl/core/drr_value_mem.sv
module drr_value_mem import drr_pkg::*; (
	input  logic   clk,
	input  logic   we,
	input  idx_t   waddr,
	input  value_t wdata,
	input  logic   re,
	input  idx_t   raddr,
	output value_t rdata
);

	value_t mem [MAX_ITEMS];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/drr_ranker.sv
module drr_ranker import drr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rank_req_t req,
	output logic      done,
	output logic      vrd_en,
	output idx_t      vrd_addr,
	input  value_t    vrd_data,
	input  code_rd_t  crd,
	output code_t     crd_data
);

	typedef enum logic [1:0] {
		RK_IDLE = 2'b01,
		RK_SCAN = 2'b10
	} rk_state_t;

	rk_state_t state_q;
	cnt_t      n_q;
	cnt_t      rd_idx_q;
	logic      vld_s1;
	idx_t      idx_s1;
	value_t    thr_q;
	logic      have_thr_q;
	code_t     rank_q;
	value_t    best_q;
	logic      best_vld_q;
	logic      done_q;

	code_t     code_mem [MAX_ITEMS];
	code_t     crd_q;

	logic      issue;
	logic      hit;
	logic      take;
	logic      pass_end;
	value_t    nxt_best;
	logic      nxt_best_vld;

	// Each pass walks the whole store once. It writes the current rank for every
	// entry equal to the threshold and looks for the smallest value above it.
	assign issue    = (state_q == RK_SCAN) && (rd_idx_q < n_q);
	assign vrd_en   = issue;
	assign vrd_addr = rd_idx_q[IDX_BITS-1:0];

	assign hit  = vld_s1 && have_thr_q && (vrd_data == thr_q);
	assign take = vld_s1 && (!have_thr_q || (vrd_data > thr_q))
		&& (!best_vld_q || (vrd_data < best_q));
	assign nxt_best     = take ? vrd_data : best_q;
	assign nxt_best_vld = best_vld_q || take;
	assign pass_end     = vld_s1 && ((cnt_t'(idx_s1) + cnt_t'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= RK_IDLE;
			n_q        <= '0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			have_thr_q <= 1'b0;
			rank_q     <= '0;
			best_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			vld_s1 <= issue;
			done_q <= 1'b0;
			unique case (state_q)
				RK_IDLE: begin
					if (req.start) begin
						n_q        <= req.count;
						rd_idx_q   <= '0;
						have_thr_q <= 1'b0;
						rank_q     <= '0;
						best_vld_q <= 1'b0;
						state_q    <= RK_SCAN;
					end
				end
				RK_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + cnt_t'(1);
					end
					if (vld_s1) begin
						best_vld_q <= nxt_best_vld;
					end
					if (pass_end) begin
						if (!nxt_best_vld) begin
							state_q <= RK_IDLE;
							done_q  <= 1'b1;
						end else begin
							have_thr_q <= 1'b1;
							rank_q     <= have_thr_q ? rank_q + code_t'(1) : '0;
							best_vld_q <= 1'b0;
							rd_idx_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= RK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_BITS-1:0];
		if (vld_s1) begin
			best_q <= nxt_best;
		end
		if (pass_end && nxt_best_vld) begin
			thr_q <= nxt_best;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			code_mem[idx_s1] <= rank_q;
		end
		if (crd.en) begin
			crd_q <= code_mem[crd.addr];
		end
	end

	assign done     = done_q;
	assign crd_data = crd_q;

endmodule
